FILE: hw/rtl/tracking_frame_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Tracking frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRACKING_FRAME_PARSER_CORE_DEFINES_SVH
`define TRACKING_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication
`define TFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tfp assertion failed");

// Next-cycle implication
`define TFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tfp assertion failed");

`endif

FILE: hw/rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// Tracking frame parser package
// Byte codes, parse step codes and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

  // Framing bytes
  localparam logic [7:0] HdrByte  = 8'h73;
  localparam logic [7:0] TypeFull = 8'h1a;
  localparam logic [7:0] TypeMode = 8'h3c;
  localparam logic [7:0] FlagMask = 8'ha0;
  localparam logic [7:0] TailByte = 8'h88;

  // Result kinds
  localparam logic KindFull = 1'b0;
  localparam logic KindMode = 1'b1;

  // Parse steps; the two unused codes fall back to hunting
  typedef enum logic [3:0] {
    StHunt  = 4'd0,
    StType  = 4'd1,
    StFlags = 4'd2,
    StYLo   = 4'd3,
    StYHi   = 4'd4,
    StXLo   = 4'd5,
    StXHi   = 4'd6,
    StHold  = 4'd7,
    StThr   = 4'd8,
    StFind  = 4'd9,
    StMode  = 4'd10,
    StFTail = 4'd11,
    StMPay  = 4'd12,
    StMTail = 4'd13
  } parse_step_e;

  // One committed record
  typedef struct packed {
    logic               frame_kind;
    logic [7:0]         found_flags;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_x;
    logic [7:0]         hold_flag;
    logic [7:0]         throttle_cmd;
    logic [7:0]         find_result;
    logic [7:0]         mode_byte;
  } rec_t;

  // Result item handed from parser to output buffer
  typedef struct packed {
    logic vld;
    rec_t rec;
  } res_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tfp_parser.sv
// ----------------------------------------------------------------------------
// Tracking frame parser: byte state machine
// Steps through one frame a byte at a time, stages fields, commits on tail.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              byte_vld_i,
  input  wire logic [7:0]        rx_byte_i,
  output tfp_pkg::res_item_t     res_o
);
  import tfp_pkg::*;

  parse_step_e step_q, step_d;

  logic [7:0]  stg_flags_q, stg_flags_d;
  logic [15:0] stg_y_q, stg_y_d;
  logic [15:0] stg_x_q, stg_x_d;
  logic [7:0]  stg_hold_q, stg_hold_d;
  logic [7:0]  stg_thr_q, stg_thr_d;
  logic [7:0]  stg_find_q, stg_find_d;
  logic [7:0]  stg_mode_q, stg_mode_d;

  logic [7:0]  hld_flags_q, hld_flags_d;
  logic [15:0] hld_y_q, hld_y_d;
  logic [15:0] hld_x_q, hld_x_d;
  logic [7:0]  hld_hold_q, hld_hold_d;
  logic [7:0]  hld_thr_q, hld_thr_d;
  logic [7:0]  hld_find_q, hld_find_d;
  logic [7:0]  hld_mode_q, hld_mode_d;

  logic emit;
  logic kind;

  // State and record registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StHunt;
      stg_flags_q <= '0;
      stg_y_q     <= '0;
      stg_x_q     <= '0;
      stg_hold_q  <= '0;
      stg_thr_q   <= '0;
      stg_find_q  <= '0;
      stg_mode_q  <= '0;
      hld_flags_q <= '0;
      hld_y_q     <= '0;
      hld_x_q     <= '0;
      hld_hold_q  <= '0;
      hld_thr_q   <= '0;
      hld_find_q  <= '0;
      hld_mode_q  <= '0;
    end else begin
      step_q      <= step_d;
      stg_flags_q <= stg_flags_d;
      stg_y_q     <= stg_y_d;
      stg_x_q     <= stg_x_d;
      stg_hold_q  <= stg_hold_d;
      stg_thr_q   <= stg_thr_d;
      stg_find_q  <= stg_find_d;
      stg_mode_q  <= stg_mode_d;
      hld_flags_q <= hld_flags_d;
      hld_y_q     <= hld_y_d;
      hld_x_q     <= hld_x_d;
      hld_hold_q  <= hld_hold_d;
      hld_thr_q   <= hld_thr_d;
      hld_find_q  <= hld_find_d;
      hld_mode_q  <= hld_mode_d;
    end
  end

  // Next step, staging and commit
  always_comb begin
    step_d      = step_q;
    stg_flags_d = stg_flags_q;
    stg_y_d     = stg_y_q;
    stg_x_d     = stg_x_q;
    stg_hold_d  = stg_hold_q;
    stg_thr_d   = stg_thr_q;
    stg_find_d  = stg_find_q;
    stg_mode_d  = stg_mode_q;
    hld_flags_d = hld_flags_q;
    hld_y_d     = hld_y_q;
    hld_x_d     = hld_x_q;
    hld_hold_d  = hld_hold_q;
    hld_thr_d   = hld_thr_q;
    hld_find_d  = hld_find_q;
    hld_mode_d  = hld_mode_q;
    emit        = 1'b0;
    kind        = KindFull;

    if (byte_vld_i) begin
      unique case (step_q)
        StHunt: begin
          if (rx_byte_i == HdrByte) step_d = StType;
        end
        StType: begin
          priority if (rx_byte_i == TypeFull) step_d = StFlags;
          else if (rx_byte_i == TypeMode)     step_d = StMPay;
          else                                step_d = StHunt;
        end
        StFlags: begin
          // flag byte kept only if a masked bit is set
          stg_flags_d = ((rx_byte_i & FlagMask) != 8'h00) ? rx_byte_i : 8'h00;
          step_d      = StYLo;
        end
        StYLo: begin
          stg_y_d = {8'h00, rx_byte_i};
          step_d  = StYHi;
        end
        StYHi: begin
          stg_y_d = {rx_byte_i, stg_y_q[7:0]};
          step_d  = StXLo;
        end
        StXLo: begin
          stg_x_d = {8'h00, rx_byte_i};
          step_d  = StXHi;
        end
        StXHi: begin
          stg_x_d = {rx_byte_i, stg_x_q[7:0]};
          step_d  = StHold;
        end
        StHold: begin
          stg_hold_d = rx_byte_i;
          step_d     = StThr;
        end
        StThr: begin
          stg_thr_d = rx_byte_i;
          step_d    = StFind;
        end
        StFind: begin
          stg_find_d = rx_byte_i;
          step_d     = StMode;
        end
        StMode: begin
          stg_mode_d = rx_byte_i;
          step_d     = StFTail;
        end
        StFTail: begin
          // good tail commits the whole staged record
          if (rx_byte_i == TailByte) begin
            hld_flags_d = stg_flags_q;
            hld_y_d     = stg_y_q;
            hld_x_d     = stg_x_q;
            hld_hold_d  = stg_hold_q;
            hld_thr_d   = stg_thr_q;
            hld_find_d  = stg_find_q;
            hld_mode_d  = stg_mode_q;
            emit        = 1'b1;
            kind        = KindFull;
          end
          step_d = StHunt;
        end
        StMPay: begin
          stg_mode_d = rx_byte_i;
          step_d     = StMTail;
        end
        StMTail: begin
          // good tail commits the mode byte only
          if (rx_byte_i == TailByte) begin
            hld_mode_d = stg_mode_q;
            emit       = 1'b1;
            kind       = KindMode;
          end
          step_d = StHunt;
        end
        default: begin
          step_d = StHunt;
        end
      endcase
    end
  end

  // Result is the held record after the commit
  always_comb begin
    res_o.vld              = emit;
    res_o.rec.frame_kind   = kind;
    res_o.rec.found_flags  = hld_flags_d;
    res_o.rec.offset_y     = hld_y_d;
    res_o.rec.offset_x     = hld_x_d;
    res_o.rec.hold_flag    = hld_hold_d;
    res_o.rec.throttle_cmd = hld_thr_d;
    res_o.rec.find_result  = hld_find_d;
    res_o.rec.mode_byte    = hld_mode_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tfp_outbuf.sv
// ----------------------------------------------------------------------------
// Tracking frame parser: result buffer
// Output register plus one skid entry so input stall is fully registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_outbuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tfp_pkg::res_item_t res_i,
  output logic                    full_o,
  output logic                    out_vld_o,
  input  wire logic               out_stall_i,
  output tfp_pkg::rec_t           out_rec_o
);
  import tfp_pkg::*;

  logic out_vld_q, out_vld_d;
  logic skd_vld_q, skd_vld_d;
  rec_t out_rec_q, out_rec_d;
  rec_t skd_rec_q, skd_rec_d;
  logic slot_free;

  // Output slot opens when empty or taken this cycle
  assign slot_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_rec_d = out_rec_q;
    skd_rec_d = skd_rec_q;
    if (slot_free) begin
      // skid entry is older than any new item
      priority if (skd_vld_q) begin
        out_vld_d = 1'b1;
        out_rec_d = skd_rec_q;
        skd_vld_d = 1'b0;
      end else if (res_i.vld) begin
        out_vld_d = 1'b1;
        out_rec_d = res_i.rec;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (res_i.vld) begin
      skd_vld_d = 1'b1;
      skd_rec_d = res_i.rec;
    end
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    out_rec_q <= out_rec_d;
    skd_rec_q <= skd_rec_d;
  end

  assign full_o    = skd_vld_q;
  assign out_vld_o = out_vld_q;
  assign out_rec_o = out_rec_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tracking_frame_parser_core.sv
// Tracking frame parser core. Takes one received byte per item and deframes
// vision-result frames (header 0x73, type 0x1a full or 0x3c mode-only, tail
// 0x88). A byte can be accepted every clock cycle while in_stall_o is low.
// The state step for a byte is combinational logic on the parse register;
// each committed record is registered in an output register with one skid
// entry, which takes it while the output side stalls, so in_stall_o rises
// only when both are occupied and the output side is stalling.
// ----------------------------------------------------------------------------
// Tracking frame parser core
// Top level: input handshake, byte parser and registered result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tracking_frame_parser_core_defines.svh"

module tracking_frame_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             frame_kind_o,
  output logic [7:0]       found_flags_o,
  output logic signed [15:0] offset_y_o,
  output logic signed [15:0] offset_x_o,
  output logic [7:0]       hold_flag_o,
  output logic [7:0]       throttle_cmd_o,
  output logic [7:0]       find_result_o,
  output logic [7:0]       mode_byte_o
);
  import tfp_pkg::*;

  logic      in_acc;
  logic      buf_full;
  res_item_t res;
  rec_t      out_rec;

  // Accept a byte whenever the skid entry is free
  assign in_acc     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  tfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (in_acc),
    .rx_byte_i  (rx_byte_i),
    .res_o      (res)
  );

  tfp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (buf_full),
    .out_vld_o   (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (out_rec)
  );

  // Result fields
  assign frame_kind_o   = out_rec.frame_kind;
  assign found_flags_o  = out_rec.found_flags;
  assign offset_y_o     = out_rec.offset_y;
  assign offset_x_o     = out_rec.offset_x;
  assign hold_flag_o    = out_rec.hold_flag;
  assign throttle_cmd_o = out_rec.throttle_cmd;
  assign find_result_o  = out_rec.find_result;
  assign mode_byte_o    = out_rec.mode_byte;

  // Checks
  `TFP_ASSERT_NOW(a_skid_implies_out, buf_full, out_valid_o)
  `TFP_ASSERT_NEXT(a_result_parks, res.vld && out_valid_o && out_stall_i, in_stall_o)
  `TFP_ASSERT_NOW(a_result_only_on_accept, res.vld, in_acc)
  `TFP_ASSERT_NOW(a_flags_filtered, res.vld,
                  (res.rec.found_flags == 8'h00) || ((res.rec.found_flags & FlagMask) != 8'h00))

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Tracking frame parser testbench
// Feeds received bytes into the core: a few hand-built frames first, then
// random frames, broken frames and noise, over phases with different sender
// gaps and receiver stalls. A record tracker follows the parse steps byte by
// byte and checks every committed record field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import tfp_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 460;
  localparam int PrintLimit  = 200;

  // Follows the deframer and holds the records still owed by the core
  class frame_record_board;
    parse_step_e step;
    rec_t        staged;
    rec_t        held;
    rec_t        owed_records[$];
    int          errors;

    function new();
      step   = StHunt;
      staged = '0;
      held   = '0;
      errors = 0;
    endfunction

    // One accepted byte moves the parse step; a good tail queues a record
    function void take_byte(logic [7:0] b);
      case (step)
        StHunt: begin
          if (b == HdrByte) step = StType;
        end
        StType: begin
          if (b == TypeFull) step = StFlags;
          else if (b == TypeMode) step = StMPay;
          else step = StHunt;
        end
        StFlags: begin
          staged.found_flags = ((b & FlagMask) != 8'h00) ? b : 8'h00;
          step = StYLo;
        end
        StYLo: begin
          staged.offset_y = {8'h00, b};
          step = StYHi;
        end
        StYHi: begin
          staged.offset_y[15:8] = b;
          step = StXLo;
        end
        StXLo: begin
          staged.offset_x = {8'h00, b};
          step = StXHi;
        end
        StXHi: begin
          staged.offset_x[15:8] = b;
          step = StHold;
        end
        StHold: begin
          staged.hold_flag = b;
          step = StThr;
        end
        StThr: begin
          staged.throttle_cmd = b;
          step = StFind;
        end
        StFind: begin
          staged.find_result = b;
          step = StMode;
        end
        StMode: begin
          staged.mode_byte = b;
          step = StFTail;
        end
        StFTail: begin
          if (b == TailByte) begin
            held = staged;
            held.frame_kind = KindFull;
            owed_records.push_back(held);
          end
          step = StHunt;
        end
        StMPay: begin
          staged.mode_byte = b;
          step = StMTail;
        end
        StMTail: begin
          // mode-only commit touches the mode byte alone
          if (b == TailByte) begin
            held.mode_byte  = staged.mode_byte;
            held.frame_kind = KindMode;
            owed_records.push_back(held);
          end
          step = StHunt;
        end
        default: begin
          step = StHunt;
        end
      endcase
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      // keep the log short on a badly broken run
      if (errors <= PrintLimit)
        $display("mismatch: %s got %h expected %h", what, got, want);
    endtask

    task check_record(rec_t got);
      rec_t want;
      if (owed_records.size() == 0) begin
        report("record with none owed, mode_byte", 16'(got.mode_byte), 16'h0);
        return;
      end
      want = owed_records.pop_front();
      if (got.frame_kind !== want.frame_kind)
        report("frame_kind", 16'(got.frame_kind), 16'(want.frame_kind));
      if (got.found_flags !== want.found_flags)
        report("found_flags", 16'(got.found_flags), 16'(want.found_flags));
      if (got.offset_y !== want.offset_y)
        report("offset_y", got.offset_y, want.offset_y);
      if (got.offset_x !== want.offset_x)
        report("offset_x", got.offset_x, want.offset_x);
      if (got.hold_flag !== want.hold_flag)
        report("hold_flag", 16'(got.hold_flag), 16'(want.hold_flag));
      if (got.throttle_cmd !== want.throttle_cmd)
        report("throttle_cmd", 16'(got.throttle_cmd), 16'(want.throttle_cmd));
      if (got.find_result !== want.find_result)
        report("find_result", 16'(got.find_result), 16'(want.find_result));
      if (got.mode_byte !== want.mode_byte)
        report("mode_byte", 16'(got.mode_byte), 16'(want.mode_byte));
    endtask
  endclass

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid_i = 1'b0;
  logic [7:0]         rx_byte_i  = 8'h00;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               frame_kind_o;
  logic [7:0]         found_flags_o;
  logic signed [15:0] offset_y_o;
  logic signed [15:0] offset_x_o;
  logic [7:0]         hold_flag_o;
  logic [7:0]         throttle_cmd_o;
  logic [7:0]         find_result_o;
  logic [7:0]         mode_byte_o;

  frame_record_board board = new();
  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent_items  = 0;
  int cycle_count = 0;
  int idle_table[4]  = '{0, 63, 0, 33};
  int stall_table[4] = '{0, 0, 63, 33};

  tracking_frame_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_kind_o   (frame_kind_o),
    .found_flags_o  (found_flags_o),
    .offset_y_o     (offset_y_o),
    .offset_x_o     (offset_x_o),
    .hold_flag_o    (hold_flag_o),
    .throttle_cmd_o (throttle_cmd_o),
    .find_result_o  (find_result_o),
    .mode_byte_o    (mode_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: check accepted records, then pick the next stall
  always @(posedge clk_i) begin
    rec_t seen;
    seen = {frame_kind_o, found_flags_o, offset_y_o, offset_x_o,
            hold_flag_o, throttle_cmd_o, find_result_o, mode_byte_o};
    if (rst_ni && out_valid_o && !out_stall_i) board.check_record(seen);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Present one byte, after random gaps, and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input bit counts);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_byte(b);
    if (counts) sent_items++;
  endtask

  task automatic send_full(input logic [7:0] flags, input logic [15:0] y, x,
                           input logic [7:0] hold, thr, find, mode, tail);
    push_byte(HdrByte, 1'b1);
    push_byte(TypeFull, 1'b1);
    push_byte(flags, 1'b1);
    push_byte(y[7:0], 1'b1);
    push_byte(y[15:8], 1'b1);
    push_byte(x[7:0], 1'b1);
    push_byte(x[15:8], 1'b1);
    push_byte(hold, 1'b1);
    push_byte(thr, 1'b1);
    push_byte(find, 1'b1);
    push_byte(mode, 1'b1);
    push_byte(tail, 1'b1);
  endtask

  task automatic send_mode(input logic [7:0] mode, tail);
    push_byte(HdrByte, 1'b1);
    push_byte(TypeMode, 1'b1);
    push_byte(mode, 1'b1);
    push_byte(tail, 1'b1);
  endtask

  // Mostly the good tail; otherwise a wrong one, often a header byte
  function automatic logic [7:0] pick_tail();
    logic [7:0] t;
    if ($urandom_range(99) < 88) return TailByte;
    if ($urandom_range(3) == 0) return HdrByte;
    do t = 8'($urandom_range(255)); while (t == TailByte);
    return t;
  endfunction

  // Random frames with random content, some broken, some noise between
  task automatic random_traffic(input int goal);
    int pick;
    int n;
    logic [7:0] flags;
    logic [7:0] kind;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        flags = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) flags = flags & ~FlagMask;
        send_full(flags, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), pick_tail());
      end else if (pick < 80) begin
        send_mode(8'($urandom_range(255)), pick_tail());
      end else if (pick < 88) begin
        do kind = 8'($urandom_range(255)); while (kind == TypeFull || kind == TypeMode);
        push_byte(HdrByte, 1'b1);
        push_byte(kind, 1'b1);
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  // Sender holds off until every owed record has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.owed_records.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Flag byte without mask bits is zeroed; offsets at their extremes
    send_full(8'h5f, 16'h8000, 16'h7fff, 8'hff, 8'h00, 8'h80, 8'h01, TailByte);
    // Mode-only frame keeps the other held fields
    send_mode(8'hff, TailByte);
    // Unknown type: a header byte in the type slot is not a new header
    push_byte(HdrByte, 1'b1);
    push_byte(HdrByte, 1'b1);
    // Bad tail drops the frame; a header byte as tail is not reused
    send_mode(8'h00, HdrByte);
    push_byte(TypeMode, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(TailByte, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_table[ph];
      stall_pct = stall_table[ph];
      random_traffic(PhaseItems * (ph + 1));
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
